>>> rtl/madcma_pkg.sv
package madcma_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MUX_W = 5;
	localparam int SLOT_W = 2;
	localparam int REG_POSITIONS = 3;
	localparam logic [MUX_W-1:0] MUX_MASK = 5'b11111;

	localparam int CHANNELS_DEF = 3;
	localparam int AVG_DEPTH_DEF = 8;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 5;

	// slot, average, next_mux packed and padded to whole bytes
	localparam int OUT_FIELDS_W = SLOT_W + SAMPLE_W + MUX_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FREE_RUN_LAG = 3'd0,
		CFG_MUX_CODE_CH0 = 3'd1,
		CFG_MUX_CODE_CH1 = 3'd2,
		CFG_MUX_CODE_CH2 = 3'd3,
		CFG_SLOT_CH0     = 3'd4,
		CFG_SLOT_CH1     = 3'd5,
		CFG_SLOT_CH2     = 3'd6
	} cfg_idx_t;

endpackage

>>> rtl/multichannel_adc_moving_average_top.sv
// channel  | dir | signals                      | contents
// ---------+-----+------------------------------+----------------------------------
// s        | in  | s_tvalid s_tready s_tdata    | sample
// m        | out | m_tvalid m_tready m_tdata    | slot, average, next_mux
// cfg      | in  | cfg_we cfg_idx cfg_data      | register write, no read-back
//
// one sample accepted per cycle unless stalled; m_tvalid is the output register
// stages: ring read and write at accept, running sum update, reciprocal multiply
// every stage holds an item while the next one is full, so a stalled output
// still lets the earlier stages fill
// arst_n clears scan position, ring pointers, fill flags and sums; rings are
// not swept, an unfilled ring entry reads as zero through its channel fill flag
module multichannel_adc_moving_average_top
	import madcma_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [SAMPLE_W-1:0]    s_tdata,    // [15:0] sample
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,    // [1:0] slot, [17:2] average, [22:18] next_mux
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int DEPTH_LOG = $clog2(AVG_DEPTH);
	localparam int SUM_W = SAMPLE_W + DEPTH_LOG;
	localparam int RECIP_SHIFT = SUM_W + DEPTH_LOG;
	localparam int MUL_W = SUM_W + 2;
	localparam longint unsigned RECIP_VAL =
		((64'd1 << RECIP_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
	localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_VAL);
	localparam int PROD_W = SUM_W + MUL_W;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(AVG_DEPTH - 1);

	// configuration
	logic                  lag_q;
	logic [MUX_W-1:0]      mux_code_q [REG_POSITIONS];
	logic [SLOT_W-1:0]     slot_cfg_q [REG_POSITIONS];

	// scan and ring state
	logic [CH_W-1:0]       scan_q;
	logic [PTR_W-1:0]      wp_q [CHANNELS];
	logic [CHANNELS-1:0]   filled_q;
	logic [SUM_W-1:0]      sum_q [CHANNELS];
	logic [SAMPLE_W-1:0]   hist_mem [CHANNELS][AVG_DEPTH];

	// stage 1
	logic                  v_s1;
	logic [SAMPLE_W-1:0]   sample_s1;
	logic [SAMPLE_W-1:0]   hist_rd_s1;
	logic                  filled_s1;
	logic [CH_W-1:0]       tgt_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [MUX_W-1:0]      mux_s1;

	// stage 2
	logic                  v_s2;
	logic [SUM_W-1:0]      sum_s2;
	logic [SLOT_W-1:0]     slot_s2;
	logic [MUX_W-1:0]      mux_s2;

	// output register
	logic                  out_valid_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [SAMPLE_W-1:0]   out_avg_q;
	logic [MUX_W-1:0]      out_mux_q;

	logic                  accept;
	logic                  adv1;
	logic                  adv2;
	logic [CH_W-1:0]       tgt;
	logic [CH_W-1:0]       nxt;
	logic [2:0]            tgt_ext;
	logic [2:0]            nxt_ext;
	logic [SLOT_W-1:0]     slot_sel;
	logic [MUX_W-1:0]      mux_sel;
	logic [PTR_W-1:0]      wp_cur;
	logic [SAMPLE_W-1:0]   old_s1;
	logic [SUM_W:0]        sum_calc;
	logic [SUM_W-1:0]      sum_new;
	logic [PROD_W-1:0]     prod;

	// handshake
	assign adv2 = v_s2 && (!out_valid_q || m_tready);
	assign adv1 = v_s1 && (!v_s2 || adv2);
	assign s_tready = !v_s1 || adv1;
	assign accept = s_tvalid && s_tready;

	// channel selection
	always_comb begin
		if (lag_q) begin
			tgt = (scan_q == '0) ? LAST_CH : scan_q - 1'b1;
		end else begin
			tgt = scan_q;
		end
		nxt = (scan_q == LAST_CH) ? '0 : scan_q + 1'b1;
		tgt_ext = 3'(tgt);
		nxt_ext = 3'(nxt);
		wp_cur = wp_q[tgt];
	end

	always_comb begin
		unique case (tgt_ext)
			3'd0: slot_sel = slot_cfg_q[0];
			3'd1: slot_sel = slot_cfg_q[1];
			3'd2: slot_sel = slot_cfg_q[2];
			default: slot_sel = tgt_ext[SLOT_W-1:0];
		endcase
		unique case (nxt_ext)
			3'd0: mux_sel = mux_code_q[0];
			3'd1: mux_sel = mux_code_q[1];
			3'd2: mux_sel = mux_code_q[2];
			default: mux_sel = MUX_W'(nxt_ext) & MUX_MASK;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q <= 1'b0;
			for (int i = 0; i < REG_POSITIONS; i++) begin
				mux_code_q[i] <= MUX_W'(i);
				slot_cfg_q[i] <= SLOT_W'(i);
			end
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_FREE_RUN_LAG: lag_q <= cfg_data[0];
				CFG_MUX_CODE_CH0: mux_code_q[0] <= cfg_data[MUX_W-1:0];
				CFG_MUX_CODE_CH1: mux_code_q[1] <= cfg_data[MUX_W-1:0];
				CFG_MUX_CODE_CH2: mux_code_q[2] <= cfg_data[MUX_W-1:0];
				CFG_SLOT_CH0:     slot_cfg_q[0] <= cfg_data[SLOT_W-1:0];
				CFG_SLOT_CH1:     slot_cfg_q[1] <= cfg_data[SLOT_W-1:0];
				CFG_SLOT_CH2:     slot_cfg_q[2] <= cfg_data[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// sample rings, read before write at one address
	always_ff @(posedge clk) begin
		if (accept) begin
			hist_rd_s1 <= hist_mem[tgt][wp_cur];
			hist_mem[tgt][wp_cur] <= s_tdata;
		end
	end

	// scan position and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			filled_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i] <= '0;
			end
		end else if (accept) begin
			scan_q <= nxt;
			if (wp_cur == LAST_PTR) begin
				wp_q[tgt] <= '0;
				filled_q[tgt] <= 1'b1;
			end else begin
				wp_q[tgt] <= wp_cur + 1'b1;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= s_tdata;
			filled_s1 <= filled_q[tgt];
			tgt_s1 <= tgt;
			slot_s1 <= slot_sel;
			mux_s1 <= mux_sel;
		end
	end

	// stage 2: running sum
	always_comb begin
		old_s1 = filled_s1 ? hist_rd_s1 : '0;
		sum_calc = {1'b0, sum_q[tgt_s1]} - (SUM_W+1)'(old_s1) + (SUM_W+1)'(sample_s1);
		sum_new = sum_calc[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			if (!v_s2 || adv2) begin
				v_s2 <= v_s1;
			end
			if (adv1) begin
				sum_q[tgt_s1] <= sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			sum_s2 <= sum_new;
			slot_s2 <= slot_s1;
			mux_s2 <= mux_s1;
		end
	end

	// division by window depth through reciprocal multiply
	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			out_slot_q <= slot_s2;
			out_avg_q <= prod[RECIP_SHIFT +: SAMPLE_W];
			out_mux_q <= mux_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_TDATA_W'({out_mux_q, out_avg_q, out_slot_q});

	// checks
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= LAST_CH)
		else $error("scan position beyond channel count");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> wp_cur <= LAST_PTR)
		else $error("ring pointer beyond window depth");

	a_s1_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stalled with stage 1 empty");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && out_valid_q && !m_tready |=> v_s2 && $stable(sum_s2))
		else $error("stage 2 item lost under output stall");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv1 |=> v_s1 && $stable(tgt_s1) && $stable(sample_s1))
		else $error("stage 1 item lost under stall");

endmodule
